// ===== rtl/bitp_pkg.sv =====
package bitp_pkg;

  localparam logic [31:0] BOOT_MAGIC        = 32'h36d7_6289;
  localparam logic [31:0] MMAP_ENTRY_BYTES  = 32'd24;
  localparam logic [31:0] SECTION_HDR_BYTES = 32'd64;
  localparam logic [31:0] HEADER_BYTES      = 32'd8;
  localparam logic [31:0] USABLE_TYPE       = 32'd1;

  localparam logic [31:0] MMAP_TYPE_RESET    = 32'd6;
  localparam logic [31:0] SECTION_TYPE_RESET = 32'd9;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // register indexes
  localparam logic [1:0] REG_LOADER_MAGIC = 2'd0;
  localparam logic [1:0] REG_MMAP_TYPE    = 2'd1;
  localparam logic [1:0] REG_SECTION_TYPE = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_REGION       = 3'd0;
  localparam logic [2:0] KIND_SECTION      = 3'd1;
  localparam logic [2:0] KIND_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] KIND_BAD_ENTRY_SZ = 3'd3;
  localparam logic [2:0] KIND_BAD_VERSION  = 3'd4;
  localparam logic [2:0] KIND_BAD_SECT_SZ  = 3'd5;

  typedef struct packed {
    logic        magic_ok;
    logic [31:0] mmap_type;
    logic [31:0] section_type;
  } cfg_t;

  // one classified word on its way to the parser
  typedef struct packed {
    logic [31:0] word;
    logic        start;
    logic        is_section_type;
    logic        is_mmap_type;
    logic        is_entry_bytes;
    logic        is_hdr_bytes;
    logic        is_zero;
    logic        is_usable;
  } q_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] base;
    logic [63:0] length;
  } result_t;

endpackage

// ===== rtl/bitp_front.sv =====
module bitp_front
  import bitp_pkg::*;
(
  input  logic [31:0] word,
  input  logic        start,
  input  cfg_t        cfg,
  output q_item_t     item
);

  // per-word compares done up front so the parser only looks at flags
  always_comb begin
    item.word            = word;
    item.start           = start;
    item.is_section_type = (word == cfg.section_type);
    item.is_mmap_type    = (word == cfg.mmap_type);
    item.is_entry_bytes  = (word == MMAP_ENTRY_BYTES);
    item.is_hdr_bytes    = (word == SECTION_HDR_BYTES);
    item.is_zero         = (word == 32'd0);
    item.is_usable       = (word == USABLE_TYPE);
  end

endmodule

// ===== rtl/bitp_queue.sv =====
module bitp_queue
  import bitp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/bitp_back.sv =====
module bitp_back
  import bitp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    magic_ok,
  input  logic    item_valid,
  input  q_item_t item,
  output logic    item_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam logic [2:0] PHASE_TYPE     = 3'd0;
  localparam logic [2:0] PHASE_SIZE     = 3'd1;
  localparam logic [2:0] PHASE_FIELDS   = 3'd2;
  localparam logic [2:0] PHASE_RESERVED = 3'd3;
  localparam logic [2:0] PHASE_ENTRIES  = 3'd4;

  localparam logic [1:0] CLASS_OTHER   = 2'd0;
  localparam logic [1:0] CLASS_MMAP    = 2'd1;
  localparam logic [1:0] CLASS_SECTION = 2'd2;

  logic        active, active_next;
  logic [31:0] info_left, info_left_next;
  logic [31:0] tag_left, tag_left_next;
  logic [31:0] data_left, data_left_next;
  logic [2:0]  phase, phase_next;
  logic [1:0]  tag_class, tag_class_next;
  logic [4:0]  word_in_entry, word_in_entry_next;
  logic [31:0] sections_left, sections_left_next;
  logic [63:0] addr_acc, addr_acc_next;
  logic [63:0] len_acc, len_acc_next;
  logic        usable, usable_next;

  logic        emit;
  result_t     emit_res;
  logic [32:0] padded;
  logic [31:0] w;

  assign item_pop = item_valid && (!res_valid || res_ready);
  assign w        = item.word;
  assign padded   = ({1'b0, w} + 33'd7) & ~33'd7;

  always_comb begin
    active_next        = active;
    info_left_next     = info_left;
    tag_left_next      = tag_left;
    data_left_next     = data_left;
    phase_next         = phase;
    tag_class_next     = tag_class;
    word_in_entry_next = word_in_entry;
    sections_left_next = sections_left;
    addr_acc_next      = addr_acc;
    len_acc_next       = len_acc;
    usable_next        = usable;
    emit               = 1'b0;
    emit_res           = '0;

    if (item.start) begin
      tag_left_next      = '0;
      data_left_next     = '0;
      phase_next         = PHASE_RESERVED;
      tag_class_next     = CLASS_OTHER;
      word_in_entry_next = '0;
      sections_left_next = '0;
      usable_next        = 1'b0;
      if (!magic_ok) begin
        active_next    = 1'b0;
        info_left_next = '0;
        emit           = 1'b1;
        emit_res.kind  = KIND_BAD_MAGIC;
      end else begin
        active_next    = 1'b1;
        info_left_next = (w > 32'd4) ? w - 32'd4 : '0;
      end
    end else if (active) begin
      if (info_left == '0) begin
        active_next = 1'b0;
      end else begin
        info_left_next = (info_left < 32'd4) ? '0 : info_left - 32'd4;
        case (phase)
          PHASE_RESERVED: begin
            phase_next = PHASE_TYPE;
          end
          PHASE_TYPE: begin
            if (item.is_section_type)   tag_class_next = CLASS_SECTION;
            else if (item.is_mmap_type) tag_class_next = CLASS_MMAP;
            else                        tag_class_next = CLASS_OTHER;
            phase_next = PHASE_SIZE;
          end
          PHASE_SIZE: begin
            if (w < HEADER_BYTES) begin
              tag_left_next  = '0;
              data_left_next = '0;
            end else begin
              tag_left_next  = padded[31:0] - HEADER_BYTES;
              data_left_next = w - HEADER_BYTES;
            end
            word_in_entry_next = '0;
            usable_next        = 1'b0;
            phase_next = (tag_left_next == '0) ? PHASE_TYPE : PHASE_FIELDS;
          end
          default: begin
            data_left_next = (data_left < 32'd4) ? '0 : data_left - 32'd4;
            tag_left_next  = (tag_left < 32'd4) ? '0 : tag_left - 32'd4;
            if (data_left != '0 && tag_class == CLASS_MMAP) begin
              if (phase == PHASE_FIELDS) begin
                // entry size word, then entry version word
                if (word_in_entry == '0) begin
                  if (!item.is_entry_bytes) begin
                    tag_class_next = CLASS_OTHER;
                    emit           = 1'b1;
                    emit_res.kind  = KIND_BAD_ENTRY_SZ;
                  end else begin
                    word_in_entry_next = 5'd1;
                  end
                end else if (!item.is_zero) begin
                  tag_class_next = CLASS_OTHER;
                  emit           = 1'b1;
                  emit_res.kind  = KIND_BAD_VERSION;
                end else begin
                  phase_next         = PHASE_ENTRIES;
                  word_in_entry_next = '0;
                end
              end else begin
                word_in_entry_next = word_in_entry + 5'd1;
                case (word_in_entry)
                  5'd0: begin
                    if (data_left < MMAP_ENTRY_BYTES) begin
                      tag_class_next     = CLASS_OTHER;
                      word_in_entry_next = word_in_entry;
                    end else begin
                      addr_acc_next = {32'd0, w};
                    end
                  end
                  5'd1: addr_acc_next = {w, addr_acc[31:0]};
                  5'd2: len_acc_next  = {32'd0, w};
                  5'd3: len_acc_next  = {w, len_acc[31:0]};
                  5'd4: usable_next   = item.is_usable;
                  default: begin
                    // reserved word closes the entry
                    word_in_entry_next = '0;
                    if (usable) begin
                      usable_next     = 1'b0;
                      emit            = 1'b1;
                      emit_res.kind   = KIND_REGION;
                      emit_res.base   = addr_acc;
                      emit_res.length = len_acc;
                    end
                  end
                endcase
              end
            end else if (data_left != '0 && tag_class == CLASS_SECTION) begin
              if (phase == PHASE_FIELDS) begin
                // count, entry size, string table index
                if (word_in_entry == 5'd0) begin
                  sections_left_next = w;
                  word_in_entry_next = 5'd1;
                end else if (word_in_entry == 5'd1) begin
                  if (!item.is_hdr_bytes) begin
                    tag_class_next = CLASS_OTHER;
                    emit           = 1'b1;
                    emit_res.kind  = KIND_BAD_SECT_SZ;
                  end else begin
                    word_in_entry_next = 5'd2;
                  end
                end else begin
                  phase_next         = PHASE_ENTRIES;
                  word_in_entry_next = '0;
                end
              end else if (word_in_entry == '0 &&
                           (sections_left == '0 || data_left < SECTION_HDR_BYTES)) begin
                tag_class_next = CLASS_OTHER;
              end else begin
                word_in_entry_next = word_in_entry + 5'd1;
                case (word_in_entry)
                  5'd4: addr_acc_next = {32'd0, w};
                  5'd5: addr_acc_next = {w, addr_acc[31:0]};
                  5'd8: len_acc_next  = {32'd0, w};
                  5'd9: begin
                    len_acc_next    = {w, len_acc[31:0]};
                    emit            = 1'b1;
                    emit_res.kind   = KIND_SECTION;
                    emit_res.base   = addr_acc;
                    emit_res.length = {w, len_acc[31:0]};
                  end
                  5'd15: begin
                    word_in_entry_next = '0;
                    sections_left_next = sections_left - 32'd1;
                  end
                  default: ;
                endcase
              end
            end
            if (tag_left_next == '0) begin
              phase_next         = PHASE_TYPE;
              tag_class_next     = CLASS_OTHER;
              word_in_entry_next = '0;
            end
          end
        endcase
        if (info_left_next == '0) active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      info_left     <= '0;
      tag_left      <= '0;
      data_left     <= '0;
      phase         <= PHASE_TYPE;
      tag_class     <= CLASS_OTHER;
      word_in_entry <= '0;
      sections_left <= '0;
      addr_acc      <= '0;
      len_acc       <= '0;
      usable        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (item_pop) begin
        active        <= active_next;
        info_left     <= info_left_next;
        tag_left      <= tag_left_next;
        data_left     <= data_left_next;
        phase         <= phase_next;
        tag_class     <= tag_class_next;
        word_in_entry <= word_in_entry_next;
        sections_left <= sections_left_next;
        addr_acc      <= addr_acc_next;
        len_acc       <= len_acc_next;
        usable        <= usable_next;
      end
      if (item_pop) res_valid <= emit;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) res <= emit_res;
  end

endmodule

// ===== rtl/boot_info_tag_region_parser_unit.sv =====
// Boot info tag parser: one 32-bit word per cycle while the result output does not stall.
// Order: the word is written into the classify queue, then popped by the parser, whose output
//   register loads the result and raises m_tvalid; a result held by m_tready stalls the pop.
// Throughput is set by the parser, which retires one queued word per cycle unless the output stalls.
// Reset (rst, synchronous): parser idle, queue empty, no result pending,
//   loader_magic = 0, memory_map_tag_type = 6, section_tag_type = 9.
module boot_info_tag_region_parser_unit
  import bitp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  // input words
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // [31:0] data_word
  input  logic          s_tuser,   // [0] start_of_info
  // results
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // [63:0] region_base, [127:64] region_length
  output logic [2:0]    m_tuser,   // [2:0] kind
  // register writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic [31:0] loader_magic;
  logic [31:0] mmap_type;
  logic [31:0] section_type;
  cfg_t        cfg;

  q_item_t     in_item;
  q_item_t     q_item;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  logic        push;
  result_t     res;

  // Register file; writes must land only while the block is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loader_magic <= '0;
      mmap_type    <= MMAP_TYPE_RESET;
      section_type <= SECTION_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOADER_MAGIC: loader_magic <= cfg_data;
        REG_MMAP_TYPE:    mmap_type    <= cfg_data;
        REG_SECTION_TYPE: section_type <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg.magic_ok     = (loader_magic == BOOT_MAGIC);
  assign cfg.mmap_type    = mmap_type;
  assign cfg.section_type = section_type;

  // Front: tag-type and field-value compares on the incoming word.
  bitp_front u_front (
    .word  (s_tdata),
    .start (s_tuser),
    .cfg   (cfg),
    .item  (in_item)
  );

  // Queue decouples input backpressure from the parser / output side.
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  bitp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_not_empty)
  );

  // Back: tag walker; pops a word whenever the output register is free or draining.
  bitp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .magic_ok   (cfg.magic_ok),
    .item_valid (q_not_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {res.length, res.base};
  assign m_tuser = res.kind;

endmodule
